@@ src/snaf_pkg.sv @@
// Shared types and constants for the strapdown altitude filter.
package snaf_pkg;

   localparam logic [16:0] GAIN_RESET    = 17'd3277;
   localparam logic [20:0] GRAVITY_RESET = 21'd642689;
   localparam logic [16:0] GAIN_ONE      = 17'd65536;

   localparam logic [1:0] REG_SIM_MODE = 2'd0;
   localparam logic [1:0] REG_GAIN     = 2'd1;
   localparam logic [1:0] REG_GRAVITY  = 2'd2;

   // datapath micro-operations
   typedef enum logic [3:0] {
      OP_LOAD    = 4'd0,  // latch the sample, start the forward rotation
      OP_ROT1    = 4'd1,  // first quaternion product, one term per cycle
      OP_ROT2    = 4'd2,  // second quaternion product, one term per cycle
      OP_GRAV    = 4'd3,  // subtract gravity from the vertical axis
      OP_VEL     = 4'd4,  // velocity update, one axis per cycle
      OP_POS     = 4'd5,  // position update, one axis per cycle
      OP_ALT     = 4'd6,  // altitude dead-reckon
      OP_BLEND1  = 4'd7,  // (1-g)*pred
      OP_BLEND2  = 4'd8,  // + g*baro, round, saturate
      OP_BACK    = 4'd9,  // start the back rotation
      OP_NOP     = 4'd10
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] idx;   // axis or term index
   } cmd_type;

   typedef struct packed {
      logic rot_done;
      logic flying;
      logic ready;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
      if (v > 80'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -80'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [79:0] v);
      if (v > 80'sd140737488355327) return 48'sh7FFFFFFFFFFF;
      if (v < -80'sd140737488355328) return 48'sh800000000000;
      return v[47:0];
   endfunction

endpackage

@@ src/snaf_datapath.sv @@
// Datapath: registers, one shared combinational multiplier and an accumulator.
module snaf_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  snaf_pkg::cmd_type      cmd,
   output snaf_pkg::status_type   status,
   input  logic                   sim_mode,
   input  logic [16:0]            gain,
   input  logic [20:0]            gravity,
   input  logic signed [31:0]     accel_x,
   input  logic signed [31:0]     accel_y,
   input  logic signed [31:0]     accel_z,
   input  logic signed [15:0]     qw,
   input  logic signed [15:0]     qx,
   input  logic signed [15:0]     qy,
   input  logic signed [15:0]     qz,
   input  logic [15:0]            dt,
   input  logic                   flying,
   input  logic signed [47:0]     baro,
   input  logic                   ready,
   output logic signed [47:0]     alt_out,
   output logic signed [31:0]     vw_out [3],
   output logic signed [47:0]     pw_out [3],
   output logic signed [31:0]     vb_out [3],
   output logic signed [31:0]     awz_out
);
   import snaf_pkg::*;

   logic signed [31:0] vec_ff [3];      // vector being rotated
   logic signed [15:0] q_ff [4];
   logic signed [16:0] qs_ff [4];       // quaternion in use (q or conjugate)
   logic signed [35:0] t_ff [4];        // intermediate quaternion
   logic signed [31:0] r_ff [3];        // rotation result
   logic signed [31:0] vel_ff [3];
   logic signed [47:0] pos_ff [3];
   logic signed [47:0] alt_ff;
   logic signed [47:0] pred_ff;
   logic signed [79:0] acc_ff;
   logic [15:0] dt_ff;
   logic flying_ff, ready_ff, back_ff;
   logic signed [47:0] baro_ff;
   logic [1:0] term_ff;                 // term of the current product
   logic [16:0] g_eff;

   // one signed product, selected by the command; a first-product row sums three terms, a second-product row four
   logic signed [47:0] ma;
   logic signed [17:0] mb;
   logic signed [65:0] mprod;
   logic signed [79:0] prod;
   logic signed [79:0] rsum;

   assign g_eff = (gain > GAIN_ONE) ? GAIN_ONE : gain;

   // first product: t[i] = sum over j of sign * q[..] * v[..]
   function automatic logic signed [17:0] sel_q1(input int i, input int j,
                                                 input logic signed [16:0] q [4]);
      // rows: tw=-x vx -y vy -z vz; tx=w vx +y vz -z vy; ty=w vy -x vz +z vx;
      // tz=w vz +x vy -y vx.  Term j of row i uses quaternion entry below.
      logic signed [17:0] r;
      r = 18'sd0;
      case ({i[1:0], j[1:0]})
         4'h0: r = -18'(q[1]); 4'h1: r = -18'(q[2]); 4'h2: r = -18'(q[3]);
         4'h4: r = 18'(q[0]);  4'h5: r = 18'(q[2]);  4'h6: r = -18'(q[3]);
         4'h8: r = 18'(q[0]);  4'h9: r = -18'(q[1]); 4'hA: r = 18'(q[3]);
         4'hC: r = 18'(q[0]);  4'hD: r = 18'(q[1]);  4'hE: r = -18'(q[2]);
         default: r = 18'sd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] sel_v1(input int i, input int j);
      logic [1:0] r;
      r = 2'd0;
      case ({i[1:0], j[1:0]})
         4'h0: r = 2'd0; 4'h1: r = 2'd1; 4'h2: r = 2'd2;
         4'h4: r = 2'd0; 4'h5: r = 2'd2; 4'h6: r = 2'd1;
         4'h8: r = 2'd1; 4'h9: r = 2'd2; 4'hA: r = 2'd0;
         4'hC: r = 2'd2; 4'hD: r = 2'd1; 4'hE: r = 2'd0;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   // second product: r0=-tw x+tx w-ty z+tz y; r1=-tw y+tx z+ty w-tz x;
   // r2=-tw z-tx y+ty x+tz w.  Term j uses t[j] with quaternion entry below.
   function automatic logic signed [17:0] sel_q2(input int i, input int j,
                                                 input logic signed [16:0] q [4]);
      logic signed [17:0] r;
      r = 18'sd0;
      case ({i[1:0], j[1:0]})
         4'h0: r = -18'(q[1]); 4'h1: r = 18'(q[0]);
         4'h2: r = -18'(q[3]); 4'h3: r = 18'(q[2]);
         4'h4: r = -18'(q[2]); 4'h5: r = 18'(q[3]);
         4'h6: r = 18'(q[0]);  4'h7: r = -18'(q[1]);
         4'h8: r = -18'(q[3]); 4'h9: r = -18'(q[2]);
         4'hA: r = 18'(q[1]);  4'hB: r = 18'(q[0]);
         default: r = 18'sd0;
      endcase
      return r;
   endfunction

   always_comb begin
      ma = 48'sd0;
      mb = 18'sd0;
      case (cmd.op)
         OP_ROT1: begin
            ma = 48'(vec_ff[sel_v1(int'(cmd.idx), int'(term_ff))]);
            mb = sel_q1(int'(cmd.idx), int'(term_ff), qs_ff);
         end
         OP_ROT2: begin
            ma = 48'(t_ff[term_ff]);
            mb = sel_q2(int'(cmd.idx), int'(term_ff), qs_ff);
         end
         OP_VEL:    begin ma = 48'(r_ff[cmd.idx]);  mb = 18'($signed({1'b0, dt_ff})); end
         OP_POS, OP_ALT: begin
            ma = 48'(vel_ff[cmd.idx]);
            mb = 18'($signed({1'b0, dt_ff}));
         end
         OP_BLEND1: begin ma = pred_ff; mb = 18'($signed({1'b0, GAIN_ONE - g_eff})); end
         OP_BLEND2: begin ma = baro_ff; mb = 18'($signed({1'b0, g_eff})); end
         default: ;
      endcase
   end

   // 48 by 18 product; the 80-bit type only sizes the sum
   assign mprod = ma * mb;
   assign prod  = 80'(mprod);
   assign rsum  = acc_ff + prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            vel_ff[i] <= '0;
            pos_ff[i] <= '0;
         end
         alt_ff      <= '0;
         term_ff     <= '0;
         back_ff     <= 1'b0;
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               vec_ff[0] <= accel_x; vec_ff[1] <= accel_y; vec_ff[2] <= accel_z;
               q_ff[0] <= qw; q_ff[1] <= qx; q_ff[2] <= qy; q_ff[3] <= qz;
               qs_ff[0] <= 17'(qw); qs_ff[1] <= 17'(qx);
               qs_ff[2] <= 17'(qy); qs_ff[3] <= 17'(qz);
               dt_ff <= dt; flying_ff <= flying; ready_ff <= ready; baro_ff <= baro;
               acc_ff <= '0; term_ff <= '0; back_ff <= 1'b0;
            end
            OP_BACK: begin
               vec_ff <= vel_ff;
               qs_ff[0] <= 17'(q_ff[0]);
               qs_ff[1] <= -17'(q_ff[1]); qs_ff[2] <= -17'(q_ff[2]);
               qs_ff[3] <= -17'(q_ff[3]);
               acc_ff <= '0; term_ff <= '0; back_ff <= 1'b1;
            end
            OP_ROT1: begin
               if (term_ff == 2'd2) begin
                  t_ff[cmd.idx] <= 36'((rsum + 80'sd8192) >>> 14);
                  acc_ff <= '0; term_ff <= '0;
               end else begin
                  acc_ff <= rsum; term_ff <= term_ff + 2'd1;
               end
            end
            OP_ROT2: begin
               if (term_ff == 2'd3) begin
                  if (back_ff) vb_out[cmd.idx] <= sat32((rsum + 80'sd8192) >>> 14);
                  else r_ff[cmd.idx] <= sat32((rsum + 80'sd8192) >>> 14);
                  acc_ff <= '0; term_ff <= '0;
               end else begin
                  acc_ff <= rsum; term_ff <= term_ff + 2'd1;
               end
            end
            OP_GRAV: r_ff[2] <= sat32(80'(r_ff[2]) - 80'($signed({1'b0, gravity})));
            OP_VEL: vel_ff[cmd.idx] <= sat32(80'(vel_ff[cmd.idx])
                                        + ((prod + 80'sd32768) >>> 16));
            OP_POS: pos_ff[cmd.idx] <= sat48(80'(pos_ff[cmd.idx])
                                        + ((prod + 80'sd32768) >>> 16));
            OP_ALT: begin
               pred_ff <= sat48(80'(alt_ff) + ((prod + 80'sd32768) >>> 16));
               if (sim_mode || !ready_ff)
                  alt_ff <= sat48(80'(alt_ff) + ((prod + 80'sd32768) >>> 16));
            end
            OP_BLEND1: acc_ff <= prod;
            OP_BLEND2: alt_ff <= sat48((rsum + 80'sd32768) >>> 16);
            default: ;
         endcase
      end
   end

   // the last term of a row retires in this cycle
   assign status.rot_done = ((cmd.op == OP_ROT1) && (term_ff == 2'd2))
                         || ((cmd.op == OP_ROT2) && (term_ff == 2'd3));
   assign status.flying   = flying_ff;
   assign status.ready    = ready_ff;
   assign alt_out = alt_ff;
   assign vw_out  = vel_ff;
   assign pw_out  = pos_ff;
   assign awz_out = r_ff[2];
endmodule

@@ src/snaf_ctrl.sv @@
// Sequencer that steps the datapath through one sample.
module snaf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  sim_mode,
   input  logic                  start,
   output logic                  busy,
   output logic                  done,
   input  snaf_pkg::status_type  status,
   output snaf_pkg::cmd_type     cmd
);
   import snaf_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_ROT1  = 10'b0000000010,
      S_ROT2  = 10'b0000000100,
      S_GRAV  = 10'b0000001000,
      S_VEL   = 10'b0000010000,
      S_POS   = 10'b0000100000,
      S_ALT   = 10'b0001000000,
      S_BL1   = 10'b0010000000,
      S_BL2   = 10'b0100000000,
      S_BACK  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic back_ff, back_in;
   logic done_ff, done_in;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      back_in  = back_ff;
      done_in  = 1'b0;
      cmd.op   = OP_NOP;
      cmd.idx  = idx_ff;
      case (state_ff)
         // latch the sample at its transfer
         S_IDLE: begin
            if (start) begin
               cmd.op = OP_LOAD; back_in = 1'b0; idx_in = '0; state_in = S_ROT1;
            end
         end
         S_ROT1: begin
            cmd.op = OP_ROT1;
            // advance the row when its last term retires
            if (status.rot_done) begin
               if (idx_ff == 2'd3) begin idx_in = '0; state_in = S_ROT2; end
               else idx_in = idx_ff + 2'd1;
            end
         end
         S_ROT2: begin
            cmd.op = OP_ROT2;
            if (status.rot_done) begin
               if (idx_ff == 2'd2) begin
                  idx_in = '0;
                  if (back_ff) begin state_in = S_IDLE; done_in = 1'b1; end
                  else state_in = S_GRAV;
               end else idx_in = idx_ff + 2'd1;
            end
         end
         S_GRAV: begin
            cmd.op = OP_GRAV;
            if (sim_mode) state_in = S_ALT;
            else if (status.flying) state_in = S_VEL;
            else state_in = S_BACK;
         end
         S_VEL: begin
            cmd.op = OP_VEL;
            if (idx_ff == 2'd2) begin idx_in = '0; state_in = S_POS; end
            else idx_in = idx_ff + 2'd1;
         end
         S_POS: begin
            cmd.op = OP_POS;
            if (idx_ff == 2'd2) state_in = S_ALT;
            else idx_in = idx_ff + 2'd1;
         end
         S_ALT: begin
            cmd.op = OP_ALT; cmd.idx = 2'd2; idx_in = '0;
            state_in = (!sim_mode && status.ready) ? S_BL1 : S_BACK;
         end
         S_BL1: begin cmd.op = OP_BLEND1; state_in = S_BL2; end
         S_BL2: begin cmd.op = OP_BLEND2; state_in = S_BACK; end
         S_BACK: begin
            cmd.op = OP_BACK; back_in = 1'b1; idx_in = '0; state_in = S_ROT1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         back_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         back_ff  <= back_in;
         done_ff  <= done_in;
      end
   end

   assign done = done_ff;
   assign busy = (state_ff != S_IDLE);
endmodule

@@ src/strapdown_nav_altitude_filter.sv @@
// Top level of the strapdown altitude filter.
// Usage:
//   req_* carries one IMU sample; it transfers when req_valid is high and
//   req_stall is low. rsp_* carries one result per sample, held in an output
//   register until the receiver drops rsp_stall.
//   p* is an APB-style port: sim_mode at 0x0, baro_blend_gain at 0x4,
//   gravity_accel at 0x8; write only while the block is idle.
// Timing:
//   Each sample is sequenced through one shared multiplier: two quaternion
//   rotations of 12+12 product terms each, the gravity step, and up to 9
//   integration and blend steps. rsp_valid rises once the back rotation has
//   ended; no new sample is taken while one is in progress, and the next
//   is taken once the result has moved to the output register. A stalled
//   output register lets one more sample run; its result then waits and
//   holds req_stall high.
// Reset:
//   Synchronous reset clears velocity, position and altitude to zero and
//   loads the register reset values; no result is pending afterwards.
module strapdown_nav_altitude_filter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_accel_body_x,
   input  logic signed [31:0] req_accel_body_y,
   input  logic signed [31:0] req_accel_body_z,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic [15:0]        req_time_step,
   input  logic               req_in_flight,
   input  logic signed [47:0] req_baro_alt,
   input  logic               req_baro_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [47:0] rsp_altitude_est,
   output logic signed [31:0] rsp_vel_world_x,
   output logic signed [31:0] rsp_vel_world_y,
   output logic signed [31:0] rsp_vel_world_z,
   output logic signed [47:0] rsp_pos_world_x,
   output logic signed [47:0] rsp_pos_world_y,
   output logic signed [47:0] rsp_pos_world_z,
   output logic signed [31:0] rsp_vel_body_x,
   output logic signed [31:0] rsp_vel_body_y,
   output logic signed [31:0] rsp_vel_body_z,
   output logic signed [31:0] rsp_accel_world_z,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import snaf_pkg::*;

   logic        sim_ff;
   logic [16:0] gain_ff;
   logic [20:0] grav_ff;
   logic        result_ff;   // datapath holds a finished result not yet moved out
   logic        start, busy, done;
   cmd_type     cmd;
   status_type  status;
   logic signed [47:0] alt;
   logic signed [31:0] vw [3];
   logic signed [47:0] pw [3];
   logic signed [31:0] vb [3];
   logic signed [31:0] awz;
   logic rsp_free;

   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         sim_ff  <= 1'b0;
         gain_ff <= GAIN_RESET;
         grav_ff <= GRAVITY_RESET;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_SIM_MODE: sim_ff  <= pwdata[0];
            REG_GAIN:     gain_ff <= pwdata[16:0];
            REG_GRAVITY:  grav_ff <= pwdata[20:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_SIM_MODE: prdata = {31'd0, sim_ff};
         REG_GAIN:     prdata = {15'd0, gain_ff};
         REG_GRAVITY:  prdata = {11'd0, grav_ff};
         default:      prdata = '0;
      endcase
   end

   assign rsp_free  = !rsp_valid || !rsp_stall;
   assign req_stall = busy || result_ff || done;
   assign start     = req_valid && !req_stall;

   snaf_ctrl u_ctrl (
      .clock, .reset, .sim_mode(sim_ff), .start, .busy, .done, .status, .cmd
   );

   snaf_datapath u_dp (
      .clock, .reset, .cmd, .status, .sim_mode(sim_ff), .gain(gain_ff),
      .gravity(grav_ff),
      .accel_x(req_accel_body_x), .accel_y(req_accel_body_y),
      .accel_z(req_accel_body_z),
      .qw(req_quat_w), .qx(req_quat_x), .qy(req_quat_y), .qz(req_quat_z),
      .dt(req_time_step), .flying(req_in_flight), .baro(req_baro_alt),
      .ready(req_baro_ready),
      .alt_out(alt), .vw_out(vw), .pw_out(pw), .vb_out(vb), .awz_out(awz)
   );

   // move the finished result to the output register when it is free
   always_ff @(posedge clock) begin
      if (reset) begin
         result_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else if ((result_ff || done) && rsp_free) begin
         result_ff <= 1'b0;
         rsp_valid <= 1'b1;
      end else begin
         if (done) result_ff <= 1'b1;
         if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((result_ff || done) && rsp_free) begin
         rsp_altitude_est  <= alt;
         rsp_vel_world_x   <= vw[0];
         rsp_vel_world_y   <= vw[1];
         rsp_vel_world_z   <= vw[2];
         rsp_pos_world_x   <= pw[0];
         rsp_pos_world_y   <= pw[1];
         rsp_pos_world_z   <= pw[2];
         rsp_vel_body_x    <= vb[0];
         rsp_vel_body_y    <= vb[1];
         rsp_vel_body_z    <= vb[2];
         rsp_accel_world_z <= awz;
      end
   end
endmodule

@@ src/snaf_checker.sv @@
// Port-level checks for the strapdown altitude filter.
module snaf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic signed [47:0] rsp_altitude_est,
   input logic pready
);
   // a sample transfer is followed by the busy stall
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("no stall after sample transfer");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_altitude_est)))
      else $error("stalled result changed");

   // no result appears right after a sample transfer
   a_lat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |=> !rsp_valid)
      else $error("result too early");

   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");
endmodule

bind strapdown_nav_altitude_filter snaf_checker u_snaf_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_altitude_est, .pready
);
